/* hdl/first_fit_pool_allocator_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the first-fit pool allocator
// Shared property forms used by the checking code at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef FIRST_FIT_POOL_ALLOCATOR_ASSERT_SVH
`define FIRST_FIT_POOL_ALLOCATOR_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FFPA_CHK_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("first_fit_pool_allocator: check failed");

// The consequent must hold in the cycle after the antecedent.
`define FFPA_CHK_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("first_fit_pool_allocator: check failed");

`endif

/* hdl/ffpa_pkg.sv */
// ----------------------------------------------------------------------------
// ffpa_pkg
// Constants, codes and types shared by the pool allocator files.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ffpa_pkg;

	localparam int MAX_BLOCKS   = 64;
	localparam int ALIGN_BYTES  = 4;
	localparam int HEADER_BYTES = 12;

	localparam int IDX_W  = $clog2(MAX_BLOCKS);
	localparam int CNT_W  = $clog2(MAX_BLOCKS + 1);
	localparam int POOL_W = 17;
	localparam int OFF_W  = 16;

	localparam logic [POOL_W-1:0] POOL_MIN   = 17'd64;
	localparam logic [POOL_W-1:0] POOL_MAX   = 17'd65536;
	localparam logic [POOL_W-1:0] POOL_RESET = 17'd65536;

	localparam logic REG_POOL_SIZE = 1'b0;

	localparam logic [1:0] REQ_ALLOC = 2'd0;
	localparam logic [1:0] REQ_FREE  = 2'd1;
	localparam logic [1:0] REQ_QUERY = 2'd2;
	localparam logic [1:0] REQ_INIT  = 2'd3;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_NO_FIT   = 2'd1;
	localparam logic [1:0] ST_FULL     = 2'd2;
	localparam logic [1:0] ST_BAD_ADDR = 2'd3;

	typedef struct packed {
		logic             used;
		logic [OFF_W-1:0] start;
	} ffpa_entry_t;

	typedef struct packed {
		logic             we;
		logic [IDX_W-1:0] addr;
		ffpa_entry_t      data;
	} ffpa_mem_wr_t;

	typedef struct packed {
		logic             idle;
		logic [CNT_W-1:0] count;
	} ffpa_stat_t;

	function automatic logic [POOL_W-1:0] clamp_pool(input logic [POOL_W-1:0] size);
		logic [POOL_W-1:0] r;
		r = size;
		if (size < POOL_MIN) begin
			r = POOL_MIN;
		end
		if (size > POOL_MAX) begin
			r = POOL_MAX;
		end
		return r;
	endfunction

endpackage

/* hdl/ffpa_req_if.sv */
// ----------------------------------------------------------------------------
// ffpa_req_if
// Request channel: valid/ready handshake with the request fields.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface ffpa_req_if import ffpa_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [1:0]       req_type;
	logic [OFF_W-1:0] request_size;
	logic [OFF_W-1:0] data_offset;

	modport source(output valid, req_type, request_size, data_offset, input ready);
	modport sink(input valid, req_type, request_size, data_offset, output ready);
endinterface

/* hdl/ffpa_rsp_if.sv */
// ----------------------------------------------------------------------------
// ffpa_rsp_if
// Response channel: valid/ready handshake with the result fields.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface ffpa_rsp_if import ffpa_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [1:0]       status;
	logic [OFF_W-1:0] result_offset;
	logic [OFF_W-1:0] free_bytes;

	modport source(output valid, status, result_offset, free_bytes, input ready);
	modport sink(input valid, status, result_offset, free_bytes, output ready);
endinterface

/* hdl/ffpa_alu.sv */
// ----------------------------------------------------------------------------
// ffpa_alu
// Shared subtractor used by every walk of the block table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ffpa_alu import ffpa_pkg::*; (
	input  logic [POOL_W-1:0] a,
	input  logic [POOL_W-1:0] b,
	output logic [POOL_W:0]   diff
);

	assign diff = {1'b0, a} - {1'b0, b};

endmodule

/* hdl/ffpa_mem.sv */
// ----------------------------------------------------------------------------
// ffpa_mem
// Block table storage: one write port and one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ffpa_mem import ffpa_pkg::*; (
	input  logic             clk,
	input  ffpa_mem_wr_t     wr,
	input  logic [IDX_W-1:0] raddr,
	output ffpa_entry_t      rdata
);

	ffpa_entry_t mem [MAX_BLOCKS];

	always_ff @(posedge clk) begin
		if (wr.we) begin
			mem[wr.addr] <= wr.data;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

/* hdl/ffpa_ctrl.sv */
// ----------------------------------------------------------------------------
// ffpa_ctrl
// Sequencer that builds, walks, splits, shifts and merges the block table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ffpa_ctrl import ffpa_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	ffpa_req_if.sink          req,
	ffpa_rsp_if.source        rsp,
	input  logic [POOL_W-1:0] pool_size,
	output ffpa_mem_wr_t      mem_wr,
	output logic [IDX_W-1:0]  mem_raddr,
	input  ffpa_entry_t       mem_rdata,
	output ffpa_stat_t        stat
);

	typedef enum logic [3:0] {
		S_INIT0, S_INIT1, S_IDLE,
		S_A_LOAD, S_A_WALK, S_A_SPLIT, S_A_INS, S_A_SET,
		S_F_WALK, S_F_NEXT, S_F_REM,
		S_Q_LOAD, S_Q_WALK, S_Q_LAST,
		S_DONE
	} state_t;

	state_t            state_q;
	logic              from_req_q;
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  idx_q;
	logic [CNT_W-1:0]  ptr_q;
	logic [1:0]        rem_n_q;
	logic [OFF_W-1:0]  cur_start_q;
	logic              cur_used_q;
	logic [POOL_W-1:0] cur_hdr_q;
	logic [OFF_W-1:0]  nxt_start_q;
	logic [OFF_W-1:0]  req_size_q;
	logic [POOL_W-1:0] need_q;
	logic [OFF_W-1:0]  off_q;
	logic              prev_used_q;
	logic [OFF_W-1:0]  pos_q;
	logic [OFF_W-1:0]  term_q;
	logic [POOL_W-1:0] total_q;
	logic [1:0]        res_st_q;
	logic [OFF_W-1:0]  res_off_q;
	logic [OFF_W-1:0]  res_fb_q;
	logic              rsp_valid_q;
	logic [1:0]        rsp_st_q;
	logic [OFF_W-1:0]  rsp_off_q;
	logic [OFF_W-1:0]  rsp_fb_q;

	logic [POOL_W-1:0] alu_a;
	logic [POOL_W-1:0] alu_b;
	logic [POOL_W:0]   alu_diff;
	logic [POOL_W-1:0] size;
	logic              a_fit;
	logic              a_last;
	logic              f_hit;
	logic              f_end;
	logic              f_left;
	logic              f_right;
	logic [OFF_W-1:0]  q_term;
	logic [POOL_W-1:0] q_sum;
	logic [OFF_W-1:0]  split_pos;
	logic [CNT_W-1:0]  rem_base;
	logic [1:0]        rem_n;
	logic [POOL_W-1:0] init_size;

	ffpa_alu u_alu (
		.a    (alu_a),
		.b    (alu_b),
		.diff (alu_diff)
	);

	assign size      = alu_diff[POOL_W-1:0];
	assign a_fit     = !cur_used_q && (size >= need_q);
	assign a_last    = (idx_q + CNT_W'(2)) >= count_q;
	assign f_hit     = alu_diff == (POOL_W + 1)'(HEADER_BYTES);
	assign f_end     = (idx_q + CNT_W'(1)) >= count_q;
	assign f_left    = (idx_q != '0) && !prev_used_q;
	assign f_right   = ((idx_q + CNT_W'(2)) < count_q) && !mem_rdata.used;
	assign q_term    = (!cur_used_q && !alu_diff[POOL_W] && (size != '0)) ?
		size[OFF_W-1:0] : '0;
	assign q_sum     = total_q + POOL_W'(term_q);
	assign split_pos = size[OFF_W-1:0] - OFF_W'(size[OFF_W-1:0] % ALIGN_BYTES)
		- OFF_W'(HEADER_BYTES);
	assign rem_base  = f_left ? idx_q : idx_q + CNT_W'(1);
	assign rem_n     = (f_left && f_right) ? 2'd2 : 2'd1;
	assign init_size = clamp_pool(pool_size) - POOL_W'(HEADER_BYTES);

	always_comb begin
		alu_a     = '0;
		alu_b     = '0;
		mem_raddr = '0;
		mem_wr    = '0;
		case (state_q)
			S_INIT0: begin
				mem_wr.we   = 1'b1;
				mem_wr.addr = '0;
				mem_wr.data = '{used: 1'b0, start: '0};
			end
			S_INIT1: begin
				mem_wr.we   = 1'b1;
				mem_wr.addr = IDX_W'(1);
				mem_wr.data = '{used: 1'b1, start: init_size[OFF_W-1:0]};
			end
			S_A_LOAD: begin
				mem_raddr = IDX_W'(1);
			end
			S_A_WALK: begin
				alu_a     = POOL_W'(mem_rdata.start);
				alu_b     = POOL_W'(cur_start_q);
				mem_raddr = IDX_W'(idx_q + CNT_W'(2));
				if (a_fit && (size == need_q)) begin
					mem_wr.we   = 1'b1;
					mem_wr.addr = idx_q[IDX_W-1:0];
					mem_wr.data = '{used: 1'b1, start: cur_start_q};
				end
			end
			S_A_SPLIT: begin
				alu_a     = POOL_W'(nxt_start_q);
				alu_b     = POOL_W'(req_size_q);
				mem_raddr = IDX_W'(count_q - CNT_W'(1));
			end
			S_A_INS: begin
				mem_raddr   = IDX_W'(ptr_q - CNT_W'(2));
				mem_wr.we   = 1'b1;
				mem_wr.addr = ptr_q[IDX_W-1:0];
				mem_wr.data = mem_rdata;
			end
			S_A_SET: begin
				mem_wr.we   = 1'b1;
				mem_wr.addr = IDX_W'(idx_q + CNT_W'(1));
				mem_wr.data = '{used: 1'b1, start: pos_q};
			end
			S_F_WALK: begin
				alu_a     = POOL_W'(off_q);
				alu_b     = POOL_W'(mem_rdata.start);
				mem_raddr = IDX_W'(idx_q + CNT_W'(1));
			end
			S_F_NEXT: begin
				mem_raddr = IDX_W'(rem_base + CNT_W'(rem_n));
				if (!f_left) begin
					mem_wr.we   = 1'b1;
					mem_wr.addr = idx_q[IDX_W-1:0];
					mem_wr.data = '{used: 1'b0, start: cur_start_q};
				end
			end
			S_F_REM: begin
				mem_raddr   = IDX_W'(ptr_q + CNT_W'(1));
				mem_wr.we   = 1'b1;
				mem_wr.addr = IDX_W'(ptr_q - CNT_W'(rem_n_q));
				mem_wr.data = mem_rdata;
			end
			S_Q_LOAD: begin
				mem_raddr = IDX_W'(1);
			end
			S_Q_WALK: begin
				alu_a     = POOL_W'(mem_rdata.start);
				alu_b     = cur_hdr_q;
				mem_raddr = IDX_W'(idx_q + CNT_W'(2));
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_INIT0;
			from_req_q  <= 1'b0;
			count_q     <= CNT_W'(2);
			rsp_valid_q <= 1'b0;
		end else begin
			if (rsp.valid && rsp.ready && (state_q != S_DONE)) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_INIT0: begin
					state_q <= S_INIT1;
				end
				S_INIT1: begin
					count_q <= CNT_W'(2);
					state_q <= from_req_q ? S_DONE : S_IDLE;
				end
				S_IDLE: begin
					if (req.valid) begin
						res_st_q   <= ST_OK;
						res_off_q  <= '0;
						res_fb_q   <= '0;
						req_size_q <= req.request_size;
						need_q     <= POOL_W'(req.request_size)
							+ POOL_W'(ALIGN_BYTES + HEADER_BYTES);
						off_q      <= req.data_offset;
						idx_q      <= '0;
						total_q    <= '0;
						term_q     <= '0;
						from_req_q <= 1'b1;
						case (req.req_type)
							REQ_ALLOC: state_q <= S_A_LOAD;
							REQ_FREE:  state_q <= S_F_WALK;
							REQ_QUERY: state_q <= S_Q_LOAD;
							default:   state_q <= S_INIT0;
						endcase
					end
				end
				S_A_LOAD: begin
					cur_start_q <= mem_rdata.start;
					cur_used_q  <= mem_rdata.used;
					state_q     <= S_A_WALK;
				end
				S_A_WALK: begin
					if (a_fit) begin
						if (size == need_q) begin
							res_off_q <= cur_start_q + OFF_W'(HEADER_BYTES);
							state_q   <= S_DONE;
						end else if (count_q >= CNT_W'(MAX_BLOCKS)) begin
							res_st_q <= ST_FULL;
							state_q  <= S_DONE;
						end else begin
							nxt_start_q <= mem_rdata.start;
							state_q     <= S_A_SPLIT;
						end
					end else if (a_last) begin
						res_st_q <= ST_NO_FIT;
						state_q  <= S_DONE;
					end else begin
						cur_start_q <= mem_rdata.start;
						cur_used_q  <= mem_rdata.used;
						idx_q       <= idx_q + CNT_W'(1);
					end
				end
				S_A_SPLIT: begin
					pos_q   <= split_pos;
					ptr_q   <= count_q;
					state_q <= S_A_INS;
				end
				S_A_INS: begin
					if ((ptr_q - CNT_W'(1)) == (idx_q + CNT_W'(1))) begin
						state_q <= S_A_SET;
					end else begin
						ptr_q <= ptr_q - CNT_W'(1);
					end
				end
				S_A_SET: begin
					count_q   <= count_q + CNT_W'(1);
					res_off_q <= pos_q + OFF_W'(HEADER_BYTES);
					state_q   <= S_DONE;
				end
				S_F_WALK: begin
					if (f_end) begin
						res_st_q <= ST_BAD_ADDR;
						state_q  <= S_DONE;
					end else if (f_hit) begin
						cur_start_q <= mem_rdata.start;
						state_q     <= S_F_NEXT;
					end else begin
						prev_used_q <= mem_rdata.used;
						idx_q       <= idx_q + CNT_W'(1);
					end
				end
				S_F_NEXT: begin
					if (!f_left && !f_right) begin
						state_q <= S_DONE;
					end else begin
						ptr_q   <= rem_base + CNT_W'(rem_n);
						rem_n_q <= rem_n;
						state_q <= S_F_REM;
					end
				end
				S_F_REM: begin
					if ((ptr_q + CNT_W'(1)) == count_q) begin
						count_q <= count_q - CNT_W'(rem_n_q);
						state_q <= S_DONE;
					end else begin
						ptr_q <= ptr_q + CNT_W'(1);
					end
				end
				S_Q_LOAD: begin
					cur_used_q <= mem_rdata.used;
					cur_hdr_q  <= POOL_W'(mem_rdata.start) + POOL_W'(HEADER_BYTES);
					state_q    <= S_Q_WALK;
				end
				S_Q_WALK: begin
					total_q    <= q_sum;
					term_q     <= q_term;
					cur_used_q <= mem_rdata.used;
					cur_hdr_q  <= POOL_W'(mem_rdata.start) + POOL_W'(HEADER_BYTES);
					if (a_last) begin
						state_q <= S_Q_LAST;
					end else begin
						idx_q <= idx_q + CNT_W'(1);
					end
				end
				S_Q_LAST: begin
					res_fb_q <= (q_sum > POOL_W'(16'hFFFF)) ? 16'hFFFF : q_sum[OFF_W-1:0];
					state_q  <= S_DONE;
				end
				S_DONE: begin
					if (!rsp_valid_q || rsp.ready) begin
						rsp_valid_q <= 1'b1;
						rsp_st_q    <= res_st_q;
						rsp_off_q   <= res_off_q;
						rsp_fb_q    <= res_fb_q;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign req.ready         = state_q == S_IDLE;
	assign rsp.valid         = rsp_valid_q;
	assign rsp.status        = rsp_st_q;
	assign rsp.result_offset = rsp_off_q;
	assign rsp.free_bytes    = rsp_fb_q;
	assign stat.idle         = state_q == S_IDLE;
	assign stat.count        = count_q;

endmodule

/* hdl/first_fit_pool_allocator.sv */
// ----------------------------------------------------------------------------
// first_fit_pool_allocator
// First-fit pool allocator with coalescing and an APB configuration register.
// ----------------------------------------------------------------------------
// The allocator keeps an address-ordered table of up to 64 blocks in a
// RAM with one write port and one read port and serves one request
// transaction at a time. Every request gives exactly one response
// transaction. The table walk reads one entry per cycle: an allocate walks
// to the first block that fits and, when it splits that block, shifts the
// later entries up to open a slot; a free walks to the block and shifts
// entries down when it merges; a query walks the whole table and an init
// rewrites its first two entries. After reset the table is built in states
// S_INIT0 and S_INIT1 before the first request is taken. The pool_size
// register at byte address 0 is used by the next init request.
`timescale 1ns / 1ps
`include "first_fit_pool_allocator_assert.svh"

module first_fit_pool_allocator import ffpa_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	ffpa_req_if.sink    req,
	ffpa_rsp_if.source  rsp,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [POOL_W-1:0] pool_size_q;
	ffpa_mem_wr_t      mem_wr;
	logic [IDX_W-1:0]  mem_raddr;
	ffpa_entry_t       mem_rdata;
	ffpa_stat_t        stat;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pool_size_q <= POOL_RESET;
		end else if (psel && penable && pwrite && (paddr[2] == REG_POOL_SIZE)) begin
			pool_size_q <= pwdata[POOL_W-1:0];
		end
	end

	assign prdata = (paddr[2] == REG_POOL_SIZE) ? 32'(pool_size_q) : '0;

	ffpa_mem u_mem (
		.clk   (clk),
		.wr    (mem_wr),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	ffpa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.rsp       (rsp),
		.pool_size (pool_size_q),
		.mem_wr    (mem_wr),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata),
		.stat      (stat)
	);

	`FFPA_CHK_NEXT(a_busy_after_accept, clk, arst_n, req.valid && req.ready, !req.ready)
	`FFPA_CHK_SAME(a_count_range, clk, arst_n, 1'b1, (stat.count >= CNT_W'(2)) && (stat.count <= CNT_W'(MAX_BLOCKS)))
	`FFPA_CHK_SAME(a_fail_zero, clk, arst_n, rsp.valid && (rsp.status != ST_OK), (rsp.result_offset == '0) && (rsp.free_bytes == '0))
	`FFPA_CHK_SAME(a_ready_idle, clk, arst_n, req.ready, stat.idle)

endmodule

/* verif/testbench.sv */
// ----------------------------------------------------------------------------
// Testbench for the first-fit pool allocator
// Sends directed and random allocate, free, query and init requests under
// random idling on both channels. It predicts every response from its own
// copy of the block table and compares each response transaction field by
// field. The pool size register is swept over several values, the extremes
// among them.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

import ffpa_pkg::*;

typedef struct {
	logic [1:0]       status;
	logic [OFF_W-1:0] offset;
	logic [OFF_W-1:0] freeb;
} alloc_resp_t;

class pool_scoreboard;
	int unsigned       pool_reg;
	int unsigned       blk_start[MAX_BLOCKS];
	bit                blk_used[MAX_BLOCKS];
	int unsigned       blk_cnt;
	alloc_resp_t       pending_resp[$];
	int unsigned       live_offsets[$];
	int unsigned       freed_offsets[$];
	int                errors;

	function new();
		errors = 0;
		pool_reg = POOL_RESET;
		rebuild();
	endfunction

	function void rebuild();
		int unsigned sz;
		sz = pool_reg;
		if (sz < POOL_MIN) begin
			sz = POOL_MIN;
		end
		if (sz > POOL_MAX) begin
			sz = POOL_MAX;
		end
		for (int i = 0; i < MAX_BLOCKS; i++) begin
			blk_start[i] = 0;
			blk_used[i] = 0;
		end
		blk_start[1] = sz - HEADER_BYTES;
		blk_used[1] = 1;
		blk_cnt = 2;
		live_offsets.delete();
		freed_offsets.delete();
	endfunction

	function void drop_entry(int unsigned k);
		for (int unsigned i = k; i + 1 < blk_cnt; i++) begin
			blk_start[i] = blk_start[i + 1];
			blk_used[i] = blk_used[i + 1];
		end
		blk_cnt--;
	endfunction

	function void add_entry(int unsigned k, int unsigned s);
		for (int unsigned i = blk_cnt; i > k; i--) begin
			blk_start[i] = blk_start[i - 1];
			blk_used[i] = blk_used[i - 1];
		end
		blk_start[k] = s;
		blk_used[k] = 1;
		blk_cnt++;
	endfunction

	function void predict_alloc(int unsigned req, ref alloc_resp_t r);
		int unsigned need;
		int unsigned i;
		int unsigned pos;
		need = req + ALIGN_BYTES + HEADER_BYTES;
		for (i = 0; i + 1 < blk_cnt; i++) begin
			if (!blk_used[i] && blk_start[i + 1] - blk_start[i] >= need) begin
				break;
			end
		end
		if (i + 1 >= blk_cnt) begin
			r.status = ST_NO_FIT;
		end else if (blk_start[i + 1] - blk_start[i] > need) begin
			if (blk_cnt >= MAX_BLOCKS) begin
				r.status = ST_FULL;
			end else begin
				pos = blk_start[i + 1] - req;
				pos = pos - (pos % ALIGN_BYTES) - HEADER_BYTES;
				add_entry(i + 1, pos);
				r.offset = OFF_W'((pos + HEADER_BYTES) & 16'hFFFF);
				live_offsets.push_back(r.offset);
			end
		end else begin
			blk_used[i] = 1;
			r.offset = OFF_W'((blk_start[i] + HEADER_BYTES) & 16'hFFFF);
			live_offsets.push_back(r.offset);
		end
	endfunction

	function void predict_free(int unsigned off, ref alloc_resp_t r);
		int unsigned i;
		for (i = 0; i + 1 < blk_cnt; i++) begin
			if (blk_start[i] + HEADER_BYTES == off) begin
				break;
			end
		end
		if (i + 1 >= blk_cnt) begin
			r.status = ST_BAD_ADDR;
			return;
		end
		foreach (live_offsets[j]) begin
			if (live_offsets[j] == off) begin
				live_offsets.delete(j);
				break;
			end
		end
		freed_offsets.push_back(off);
		if (freed_offsets.size() > 8) begin
			void'(freed_offsets.pop_front());
		end
		blk_used[i] = 0;
		if (i > 0 && !blk_used[i - 1]) begin
			drop_entry(i);
			i--;
		end
		if (i + 2 < blk_cnt && !blk_used[i + 1]) begin
			drop_entry(i + 1);
		end
	endfunction

	function void predict_query(ref alloc_resp_t r);
		int unsigned total;
		int unsigned sz;
		total = 0;
		for (int unsigned i = 0; i + 1 < blk_cnt; i++) begin
			if (!blk_used[i]) begin
				sz = blk_start[i + 1] - blk_start[i];
				if (sz > HEADER_BYTES) begin
					total += sz - HEADER_BYTES;
				end
			end
		end
		r.freeb = (total > 16'hFFFF) ? 16'hFFFF : OFF_W'(total);
	endfunction

	function void note_request(logic [1:0] kind, logic [15:0] size, logic [15:0] off);
		alloc_resp_t r;
		r.status = ST_OK;
		r.offset = '0;
		r.freeb = '0;
		case (kind)
			REQ_ALLOC: begin
				predict_alloc(size, r);
			end
			REQ_FREE: begin
				predict_free(off, r);
			end
			REQ_QUERY: begin
				predict_query(r);
			end
			default: begin
				rebuild();
			end
		endcase
		pending_resp.push_back(r);
	endfunction

	task report(string what, int got, int want);
		$display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
		errors++;
	endtask

	task check_response(logic [1:0] st, logic [15:0] off, logic [15:0] fb);
		alloc_resp_t r;
		if (pending_resp.size() == 0) begin
			report("unexpected response transaction", st, -1);
			return;
		end
		r = pending_resp.pop_front();
		if (st !== r.status) begin
			report("status", st, r.status);
		end
		if (off !== r.offset) begin
			report("result_offset", off, r.offset);
		end
		if (fb !== r.freeb) begin
			report("free_bytes", fb, r.freeb);
		end
	endtask
endclass

module testbench;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int HOLD_CYCLES    = 500;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	bit          calm;
	bit          hold_request;
	int          quiet_cycles;

	ffpa_req_if req_ch();
	ffpa_rsp_if rsp_ch();

	pool_scoreboard sb = new();

	first_fit_pool_allocator u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req_ch.sink),
		.rsp     (rsp_ch.source),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	initial begin
		clk = 1'b0;
	end

	always #6 clk = ~clk;

	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
		end else if (hold_request) begin
			rsp_ch.ready <= 1'b0;
			repeat (HOLD_CYCLES) @(negedge clk);
			hold_request = 1'b0;
		end else begin
			rsp_ch.ready <= calm || ($urandom_range(0, 99) >= 37);
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			sb.check_response(rsp_ch.status, rsp_ch.result_offset, rsp_ch.free_bytes);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	task automatic send_request(logic [1:0] kind, logic [15:0] size, logic [15:0] off);
		while (!calm && $urandom_range(0, 99) < 37) begin
			@(negedge clk);
			req_ch.valid = 1'b0;
		end
		@(negedge clk);
		req_ch.valid = 1'b1;
		req_ch.req_type = kind;
		req_ch.request_size = size;
		req_ch.data_offset = off;
		do begin
			@(posedge clk);
		end while (!req_ch.ready);
		sb.note_request(kind, size, off);
	endtask

	task automatic wait_idle();
		@(negedge clk);
		req_ch.valid = 1'b0;
		while (sb.pending_resp.size() != 0) begin
			@(posedge clk);
		end
		repeat (100) @(posedge clk);
	endtask

	task automatic write_pool_size(logic [31:0] value);
		@(negedge clk);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = 3'(REG_POOL_SIZE) << 2;
		pwdata = value;
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		sb.pool_reg = value & 32'h1FFFF;
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
	endtask

	task automatic random_request(int unsigned pool);
		int          r;
		int unsigned sz;
		int unsigned off;
		r = $urandom_range(0, 99);
		if (r < 48) begin
			r = $urandom_range(0, 99);
			if (r < 70) begin
				sz = $urandom_range(0, 64);
			end else if (r < 92) begin
				sz = $urandom_range(0, pool / 8);
			end else begin
				sz = $urandom() & 16'hFFFF;
			end
			send_request(REQ_ALLOC, 16'(sz), 16'($urandom()));
		end else if (r < 82) begin
			r = $urandom_range(0, 99);
			if (r < 80 && sb.live_offsets.size() > 0) begin
				off = sb.live_offsets[$urandom_range(0, sb.live_offsets.size() - 1)];
			end else if (r < 90 && sb.freed_offsets.size() > 0) begin
				off = sb.freed_offsets[$urandom_range(0, sb.freed_offsets.size() - 1)];
			end else begin
				off = $urandom() & 16'hFFFF;
			end
			send_request(REQ_FREE, 16'($urandom()), 16'(off));
		end else if (r < 97) begin
			send_request(REQ_QUERY, 16'($urandom()), 16'($urandom()));
		end else begin
			send_request(REQ_INIT, 16'($urandom()), 16'($urandom()));
		end
	endtask

	initial begin
		int unsigned pools[6];
		int unsigned first_off;
		pools = '{65536, 64, 0, 131071, 4096, 0};
		pools[5] = $urandom_range(64, 65536);
		arst_n = 1'b0;
		calm = 1'b0;
		hold_request = 1'b0;
		quiet_cycles = 0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		req_ch.valid = 1'b0;
		req_ch.req_type = REQ_QUERY;
		req_ch.request_size = '0;
		req_ch.data_offset = '0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		send_request(REQ_QUERY, 16'hFFFF, 16'hFFFF);
		send_request(REQ_ALLOC, 16'h0000, 16'h0000);
		first_off = sb.live_offsets[0];
		send_request(REQ_ALLOC, 16'hFFFF, 16'h0000);
		send_request(REQ_ALLOC, 16'd65508, 16'h0000);
		send_request(REQ_ALLOC, 16'd100, 16'h0000);
		send_request(REQ_ALLOC, 16'd5, 16'h0000);
		send_request(REQ_FREE, 16'h0000, 16'h0001);
		send_request(REQ_FREE, 16'h0000, 16'hFFFF);
		send_request(REQ_FREE, 16'h0000, 16'h0000);
		send_request(REQ_FREE, 16'h0000, 16'(first_off));
		send_request(REQ_FREE, 16'h0000, 16'(first_off));
		send_request(REQ_QUERY, 16'h0000, 16'h0000);
		send_request(REQ_FREE, 16'h0000, 16'd12);
		send_request(REQ_QUERY, 16'h0000, 16'h0000);
		send_request(REQ_INIT, 16'h0000, 16'h0000);
		send_request(REQ_QUERY, 16'h0000, 16'h0000);
		for (int i = 0; i < 66; i++) begin
			send_request(REQ_ALLOC, 16'd8, 16'h0000);
		end
		send_request(REQ_QUERY, 16'h0000, 16'h0000);

		for (int ph = 0; ph < 6; ph++) begin
			wait_idle();
			write_pool_size(pools[ph]);
			send_request(REQ_INIT, 16'($urandom()), 16'($urandom()));
			for (int n = 0; n < 210; n++) begin
				calm = (ph == 2 && n < 60);
				if (ph == 0 && n == 30) begin
					hold_request = 1'b1;
				end
				random_request(pools[ph] < 64 ? 64 : (pools[ph] > 65536 ? 65536 : pools[ph]));
			end
			calm = 1'b0;
		end

		wait_idle();
		if (sb.errors == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end
endmodule
